// ===== rtl/text_terminal_cell_buffer_defines.svh =====
// Assertion macros used by the text cell buffer sequencer RTL.
`ifndef TEXT_TERMINAL_CELL_BUFFER_DEFINES_SVH
`define TEXT_TERMINAL_CELL_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge out of reset.
`define TTCB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("text cell buffer check failed");
// Check that a condition in one cycle implies another in the next.
`define TTCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text cell buffer sequence check failed");
`else
`define TTCB_ASSERT(label, clk, rst_n, prop)
`define TTCB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/ttcb_pkg.sv =====
// Types and character codes shared by the text cell buffer modules.
package ttcb_pkg;

    typedef logic [6:0] cell_t;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    localparam logic MODE_PRINT = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PAD,
        ST_READ,
        ST_EMIT
    } ttcb_state_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_in;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } ttcb_item_t;

    typedef struct packed {
        logic       done;
        cell_t      cell_value;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } ttcb_result_t;

endpackage

// ===== rtl/text_terminal_cell_buffer.sv =====
// Top level of the text cell buffer: input handshake, sequencer, cell store, output register.
// Print steps: EXEC, EMIT; cell read: EXEC, READ, EMIT; EMIT loads the output register.
// No new word is taken until the last leaves EMIT; EMIT stalls while a held result waits.
// Line feed first zeroes the unfilled columns of the cursor row, one cell a cycle.
// Scroll and form feed cost nothing: a row ring offset and a fill mark hide stale cells.
// Reset (aresetn low, synchronous) homes cursor and ring; no clearing pass is needed.
module text_terminal_cell_buffer #(
    parameter int NUM_ROWS = 25,
    parameter int NUM_COLS = 80
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic [7:0] s_byte_in,
    input  logic [4:0] s_read_row,
    input  logic [6:0] s_read_col,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_cell_value,
    output logic [4:0] m_cursor_row,
    output logic [6:0] m_cursor_col
);
    import ttcb_pkg::*;

    localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int CW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
    localparam int AW = RW + CW;

    ttcb_item_t    item;
    ttcb_result_t  result;
    logic          ctrl_idle;
    logic          out_free;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    cell_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    cell_t         mem_rdata;

    // output word register; it parts the sequencer from the result side
    logic          m_valid_reg, m_valid_next;
    cell_t         m_cell_value_reg;
    logic [4:0]    m_cursor_row_reg;
    logic [6:0]    m_cursor_col_reg;

    assign item.mode     = s_mode;
    assign item.byte_in  = s_byte_in;
    assign item.read_row = s_read_row;
    assign item.read_col = s_read_col;

    // take a new word whenever the sequencer is idle, even with a result still held
    assign s_ready  = ctrl_idle;
    // the held word leaves this cycle or none is held
    assign out_free = !m_valid_reg || m_ready;

    ttcb_ctrl #(
        .NUM_ROWS (NUM_ROWS),
        .NUM_COLS (NUM_COLS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid),
        .item      (item),
        .out_free  (out_free),
        .idle      (ctrl_idle),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ttcb_cell_ram #(
        .AW (AW)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (result.done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // load the payload only when a finished word arrives; hold it otherwise
    always_ff @(posedge aclk) begin
        if (result.done) begin
            m_cell_value_reg <= result.cell_value;
            m_cursor_row_reg <= result.cursor_row;
            m_cursor_col_reg <= result.cursor_col;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_value = m_cell_value_reg;
    assign m_cursor_row = m_cursor_row_reg;
    assign m_cursor_col = m_cursor_col_reg;

endmodule

// ===== rtl/ttcb_cell_ram.sv =====
// Character cell store: one write port, one registered read port.
module ttcb_cell_ram #(
    parameter int AW = 12
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  ttcb_pkg::cell_t    wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output ttcb_pkg::cell_t    rdata
);
    import ttcb_pkg::*;

    localparam int DEPTH = 1 << AW;

    cell_t mem [DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ttcb_ctrl.sv =====
// Command sequencer: cursor, row ring offset, fill mark and cell store access.
`include "text_terminal_cell_buffer_defines.svh"

module ttcb_ctrl #(
    parameter int NUM_ROWS = 25,
    parameter int NUM_COLS = 80,
    localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1,
    localparam int CW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1,
    localparam int AW = RW + CW
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  ttcb_pkg::ttcb_item_t   item,
    input  logic                   out_free,
    output logic                   idle,
    output ttcb_pkg::ttcb_result_t result,
    output logic                   mem_we,
    output logic [AW-1:0]          mem_waddr,
    output ttcb_pkg::cell_t        mem_wdata,
    output logic                   mem_re,
    output logic [AW-1:0]          mem_raddr,
    input  ttcb_pkg::cell_t        mem_rdata
);
    import ttcb_pkg::*;

    localparam int SW = ((RW > 5) ? RW : 5) + 1;
    localparam int KW = ((CW > 7) ? CW : 7) + 1;
    localparam logic [RW-1:0] LAST_ROW  = RW'(NUM_ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(NUM_COLS - 1);
    localparam logic [CW:0]   FULL_FILL = (CW + 1)'(NUM_COLS);

    ttcb_state_t   state_reg, state_next;
    ttcb_item_t    item_reg;
    logic [RW-1:0] top_reg, top_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] pad_reg, pad_next;
    logic [CW:0]   fill_reg, fill_next;
    logic          hit_reg, hit_next;
    cell_t         value_reg, value_next;

    logic [RW:0]   cur_sum;
    logic [RW-1:0] phys_cur;
    logic [SW-1:0] rd_sum;
    logic [RW-1:0] phys_rd;
    logic          rd_in_range;
    logic          rd_written;
    logic          printable;
    logic [RW-1:0] top_wrapped;
    logic          newline;

    // physical row of the cursor and of the addressed read row
    assign cur_sum  = {1'b0, top_reg} + {1'b0, row_reg};
    assign phys_cur = (cur_sum >= (RW + 1)'(NUM_ROWS)) ?
                      RW'(cur_sum - (RW + 1)'(NUM_ROWS)) : cur_sum[RW-1:0];
    assign rd_sum   = SW'(top_reg) + SW'(item_reg.read_row);
    assign phys_rd  = (rd_sum >= SW'(NUM_ROWS)) ?
                      RW'(rd_sum - SW'(NUM_ROWS)) : RW'(rd_sum);

    assign rd_in_range = (SW'(item_reg.read_row) < SW'(NUM_ROWS)) &&
                         (KW'(item_reg.read_col) < KW'(NUM_COLS));
    // rows above the cursor are complete; the cursor row is valid below the fill mark
    assign rd_written  = (SW'(item_reg.read_row) < SW'(row_reg)) ||
                         ((SW'(item_reg.read_row) == SW'(row_reg)) &&
                          (KW'(item_reg.read_col) < KW'(fill_reg)));

    assign printable   = (item_reg.byte_in >= CH_SPACE) && (item_reg.byte_in < CH_DEL);
    assign top_wrapped = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
    assign idle        = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (item_reg.mode == MODE_READ) begin
                    state_next = ST_READ;
                end else if (item_reg.byte_in == CH_LF && fill_reg != FULL_FILL) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_PAD: begin
                if (pad_reg == LAST_COL) begin
                    state_next = ST_EMIT;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        top_next   = top_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        pad_next   = pad_reg;
        fill_next  = fill_reg;
        hit_next   = hit_reg;
        value_next = value_reg;
        newline    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = {phys_cur, col_reg};
        mem_wdata  = item_reg.byte_in[6:0];
        mem_re     = 1'b0;
        mem_raddr  = {phys_rd, CW'(item_reg.read_col)};
        result.done       = 1'b0;
        result.cell_value = value_reg;
        result.cursor_row = 5'(row_reg);
        result.cursor_col = 7'(col_reg);

        unique case (state_reg)
            ST_IDLE: begin
                hit_next = 1'b0;
            end
            ST_EXEC: begin
                value_next = '0;
                if (item_reg.mode == MODE_READ) begin
                    mem_re   = 1'b1;
                    hit_next = rd_in_range && rd_written;
                end else begin
                    unique case (item_reg.byte_in)
                        CH_LF: begin
                            // a full row moves on at once, otherwise zero its tail first
                            if (fill_reg == FULL_FILL) begin
                                newline = 1'b1;
                            end else begin
                                pad_next = fill_reg[CW-1:0];
                            end
                        end
                        CH_CR: begin
                            col_next = '0;
                        end
                        CH_BS: begin
                            if (col_reg != '0) begin
                                col_next  = col_reg - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = {phys_cur, col_next};
                                mem_wdata = CH_SPACE[6:0];
                            end
                        end
                        CH_FF: begin
                            // rows past the cursor read as empty, so homing clears all
                            row_next  = '0;
                            col_next  = '0;
                            fill_next = '0;
                        end
                        default: begin
                            if (printable) begin
                                mem_we = 1'b1;
                                if ((CW + 1)'(col_reg) + 1'b1 > fill_reg) begin
                                    fill_next = (CW + 1)'(col_reg) + 1'b1;
                                end
                                if (col_reg == LAST_COL) begin
                                    newline = 1'b1;
                                end else begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_PAD: begin
                mem_we    = 1'b1;
                mem_waddr = {phys_cur, pad_reg};
                mem_wdata = '0;
                if (pad_reg == LAST_COL) begin
                    newline = 1'b1;
                end else begin
                    pad_next = pad_reg + 1'b1;
                end
            end
            ST_READ: begin
                value_next = hit_reg ? mem_rdata : '0;
            end
            ST_EMIT: begin
                result.done = out_free;
            end
            default: begin
                hit_next = 1'b0;
            end
        endcase

        // advance a row; at the bottom rotate the ring so the new row is empty
        if (newline) begin
            col_next  = '0;
            fill_next = '0;
            if (row_reg == LAST_ROW) begin
                top_next = top_wrapped;
            end else begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            top_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            fill_reg  <= '0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            fill_reg  <= fill_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        pad_reg   <= pad_next;
        value_reg <= value_next;
        if (start && state_reg == ST_IDLE) begin
            item_reg <= item;
        end
    end

    `TTCB_ASSERT(a_fill_max, aclk, aresetn, fill_reg <= FULL_FILL)
    `TTCB_ASSERT(a_col_below_fill, aclk, aresetn, (CW + 1)'(col_reg) <= fill_reg)
    `TTCB_ASSERT(a_rows_range, aclk, aresetn, top_reg <= LAST_ROW && row_reg <= LAST_ROW)
    `TTCB_ASSERT_NEXT(a_emit_frees, aclk, aresetn, result.done, state_reg == ST_IDLE)

endmodule
